/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ostt_pkg.sv */
package ostt_pkg;

	typedef enum logic [2:0] {
		OP_SCHEDULE   = 3'd0,
		OP_REMOVE     = 3'd1,
		OP_REMOVE_ALL = 3'd2,
		OP_TICK       = 3'd3,
		OP_SET_RUN    = 3'd4,
		OP_FREEZE     = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_ACK    = 2'd0,
		KIND_EXPIRE = 2'd1,
		KIND_DONE   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	localparam int ID_W = 32;
	localparam int IN_TDATA_W = 72;
	localparam int OUT_TDATA_W = 40;

endpackage

/* rtl/one_shot_timer_table_unit.sv */
// One-shot timer table. Up to SLOTS timers are kept in scheduling order in
// three small memories (remaining time, id, pause bit) that one sequencer
// reads and writes one entry per cycle, while the output does not stall it,
// through a single shared compare and subtract unit. Each input transaction
// carries opcode, time_value, timer_id and flag; each output transaction
// carries kind, result_id, status and last (tlast), and every input
// transaction ends with exactly one transaction that has tlast set.
// Schedule, remove all and unused opcodes go straight to the result. Remove,
// freeze and set global run walk the live entries, one entry per cycle, and
// a remove then closes up the entries behind the removed one, one per cycle.
// A tick walks every live entry once, one per cycle, and compacts surviving
// entries in the same pass; it holds on an expiring entry while the output
// register is not free. The input side is not ready while an item is being
// worked on. No clearing pass follows reset.
module one_shot_timer_table_unit #(
	parameter int SLOTS     = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0: opcode[2:0], time_value[34:3], timer_id[66:35],
	// flag[67], zero fill to bit 71.
	input  logic [ostt_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// Fields from bit 0: kind[1:0], result_id[33:2], status[35:34],
	// zero fill to bit 39.
	output logic [ostt_pkg::OUT_TDATA_W-1:0] m_tdata,
	// Marks the final result of an input transaction.
	output logic                            m_tlast
);
	import ostt_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SHIFT, S_EMIT, S_WAIT
	} state_t;

	// Table memories.
	logic [TIME_BITS-1:0] rem_mem [SLOTS];
	logic [ID_W-1:0]      id_mem  [SLOTS];
	logic                 pau_mem [SLOTS];

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        rd_q;      // read pointer
	logic [CW-1:0]        wr_q;      // write pointer (compaction)
	logic [ID_W-1:0]      idc_q;
	logic                 run_q;
	logic [2:0]           op_q;
	logic [TIME_BITS-1:0] tv_q;
	logic [ID_W-1:0]      tid_q;
	logic                 flag_q;
	logic                 found_q;
	logic                 out_v_q;
	logic [1:0]           kind_q;
	logic [ID_W-1:0]      rid_q;
	logic [1:0]           st_q;
	logic                 last_q;

	logic [IW-1:0]        rd_idx;
	logic [IW-1:0]        wr_idx;
	logic [TIME_BITS-1:0] rem_rd;
	logic [ID_W-1:0]      id_rd;
	logic                 pau_rd;
	logic                 expire;
	logic [TIME_BITS-1:0] rem_dec;
	logic                 out_free;
	logic                 out_load;
	logic                 sched_ok;
	logic                 ptr_order_ok;

	assign rd_idx   = rd_q[IW-1:0];
	assign wr_idx   = wr_q[IW-1:0];
	assign rem_rd   = rem_mem[rd_idx];
	assign id_rd    = id_mem[rd_idx];
	assign pau_rd   = pau_mem[rd_idx];
	// Shared compare and subtract unit.
	assign expire   = rem_rd < tv_q;
	assign rem_dec  = rem_rd - tv_q;
	assign out_free = !out_v_q || m_tready;
	// A schedule request that finds a free slot.
	assign sched_ok = s_tdata[2:0] == OP_SCHEDULE && count_q < CW'(SLOTS);
	// The output register takes a new transaction in this cycle.
	assign out_load = (state_q == S_EMIT) || (state_q == S_WAIT && out_free) ||
		(state_q == S_SCAN && op_q == OP_TICK && rd_q < count_q && !pau_rd &&
		expire && out_free);
	assign ptr_order_ok = wr_q <= rd_q || state_q inside {S_IDLE, S_EMIT};

	assign s_tready = (state_q == S_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(OUT_TDATA_W - 36){1'b0}}, st_q, rid_q, kind_q};
	assign m_tlast  = last_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid && s_tready && sched_ok) begin
			rem_mem[count_q[IW-1:0]] <= TIME_BITS'(s_tdata[34:3]);
			id_mem[count_q[IW-1:0]]  <= idc_q + 1'b1;
			pau_mem[count_q[IW-1:0]] <= !run_q;
		end else if (state_q == S_SCAN && rd_q < count_q) begin
			case (op_q)
				OP_TICK: begin
					if (pau_rd || !expire) begin
						rem_mem[wr_idx] <= pau_rd ? rem_rd : rem_dec;
						id_mem[wr_idx]  <= id_rd;
						pau_mem[wr_idx] <= pau_rd;
					end
				end
				OP_SET_RUN: pau_mem[rd_idx] <= !flag_q;
				OP_FREEZE: begin
					if (id_rd == tid_q && !found_q) begin
						pau_mem[rd_idx] <= flag_q;
					end
				end
				default: ;
			endcase
		end else if (state_q == S_SHIFT && rd_q < count_q) begin
			rem_mem[wr_idx] <= rem_rd;
			id_mem[wr_idx]  <= id_rd;
			pau_mem[wr_idx] <= pau_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			idc_q   <= '0;
			run_q   <= 1'b1;
			found_q <= 1'b0;
			out_v_q <= 1'b0;
			last_q  <= 1'b0;
			op_q    <= '0;
			flag_q  <= 1'b0;
			tv_q    <= '0;
			tid_q   <= '0;
			kind_q  <= KIND_ACK;
			rid_q   <= '0;
			st_q    <= ST_OK;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q    <= s_tdata[2:0];
						tv_q    <= TIME_BITS'(s_tdata[34:3]);
						tid_q   <= s_tdata[35 +: ID_W];
						flag_q  <= s_tdata[67];
						rd_q    <= '0;
						wr_q    <= '0;
						found_q <= 1'b0;
						kind_q  <= KIND_ACK;
						rid_q   <= sched_ok ? idc_q + 1'b1 : '0;
						st_q    <= (s_tdata[2:0] == OP_SCHEDULE && !sched_ok) ?
							ST_FULL : ST_OK;
						last_q  <= 1'b1;
						state_q <= (s_tdata[2:0] inside
							{OP_REMOVE, OP_TICK, OP_SET_RUN, OP_FREEZE}) ? S_SCAN : S_EMIT;
						case (s_tdata[2:0])
							OP_SCHEDULE: begin
								if (sched_ok) begin
									idc_q   <= idc_q + 1'b1;
									count_q <= count_q + 1'b1;
								end
							end
							OP_REMOVE_ALL: count_q <= '0;
							OP_SET_RUN: run_q <= s_tdata[67];
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (rd_q < count_q) begin
						case (op_q)
							OP_TICK: begin
								if (!pau_rd && expire) begin
									if (out_free) begin
										kind_q  <= KIND_EXPIRE;
										rid_q   <= id_rd;
										st_q    <= ST_OK;
										last_q  <= 1'b0;
										rd_q    <= rd_q + 1'b1;
									end
								end else begin
									rd_q <= rd_q + 1'b1;
									wr_q <= wr_q + 1'b1;
								end
							end
							OP_REMOVE: begin
								if (id_rd == tid_q) begin
									found_q <= 1'b1;
									wr_q    <= rd_q;
									rd_q    <= rd_q + 1'b1;
									state_q <= S_SHIFT;
								end else begin
									rd_q <= rd_q + 1'b1;
								end
							end
							OP_FREEZE: begin
								if (id_rd == tid_q) begin
									found_q <= 1'b1;
									state_q <= S_WAIT;
								end else begin
									rd_q <= rd_q + 1'b1;
								end
							end
							default: rd_q <= rd_q + 1'b1;
						endcase
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_SHIFT: begin
					if (rd_q < count_q) begin
						rd_q <= rd_q + 1'b1;
						wr_q <= wr_q + 1'b1;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					// Final result once the output register is free.
					if (out_free) begin
						kind_q  <= (op_q == OP_TICK) ? KIND_DONE : KIND_ACK;
						rid_q   <= '0;
						st_q    <= (op_q inside {OP_REMOVE, OP_FREEZE} && !found_q) ?
							ST_NOT_FOUND : ST_OK;
						last_q  <= 1'b1;
						state_q <= S_IDLE;
						case (op_q)
							OP_TICK: count_q <= wr_q;
							OP_REMOVE: begin
								if (found_q) begin
									count_q <= count_q - 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_EMIT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(SLOTS), "count over SLOTS")
	`ASSERT_ALWAYS(a_wr_le_rd, clk, arst_n, ptr_order_ok, "compaction pointer ahead")
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, s_tvalid && s_tready, !s_tready, "accepted while busy")

endmodule

/* tb/sv/one_shot_timer_table_unit_test.sv */
module one_shot_timer_table_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ostt_pkg::*;

	localparam int SLOTS = 16;

	// One expected output transaction.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] result_id;
		status_t     status;
		logic        last;
	} timer_result_t;

	// Tracks the timer table as the block should hold it and keeps the output
	// transactions that are still owed, oldest first.
	class timer_table_scoreboard;
		logic [31:0]   remaining [SLOTS];
		logic [31:0]   ident [SLOTS];
		logic          paused [SLOTS];
		int            live_count;
		logic [31:0]   id_counter;
		logic          run_bit;
		timer_result_t owed_results[$];
		int            mismatches;
		int            checked;
		int            expiries;

		function void clear();
			live_count = 0;
			id_counter = '0;
			run_bit = 1'b1;
			owed_results.delete();
			mismatches = 0;
			checked = 0;
			expiries = 0;
		endfunction

		function void owe(kind_t k, logic [31:0] id, status_t st, logic lst);
			timer_result_t r;
			r.kind = k;
			r.result_id = id;
			r.status = st;
			r.last = lst;
			owed_results.insert(owed_results.size(), r);
		endfunction

		function int locate(logic [31:0] id);
			for (int i = 0; i < live_count; i++)
				if (ident[i] == id) return i;
			return -1;
		endfunction

		function void close_up(int pos);
			for (int i = pos; i + 1 < live_count; i++) begin
				remaining[i] = remaining[i + 1];
				ident[i] = ident[i + 1];
				paused[i] = paused[i + 1];
			end
			live_count--;
		endfunction

		// Applies one accepted input transaction to the table.
		function void note_command(logic [2:0] op, logic [31:0] tv, logic [31:0] tid,
			logic flag);
			int pos;
			int i;
			case (op)
				OP_SCHEDULE: begin
					if (live_count >= SLOTS) begin
						owe(KIND_ACK, '0, ST_FULL, 1'b1);
					end else begin
						id_counter++;
						remaining[live_count] = tv;
						ident[live_count] = id_counter;
						paused[live_count] = !run_bit;
						live_count++;
						owe(KIND_ACK, id_counter, ST_OK, 1'b1);
					end
				end
				OP_REMOVE: begin
					pos = locate(tid);
					if (pos < 0) begin
						owe(KIND_ACK, '0, ST_NOT_FOUND, 1'b1);
					end else begin
						close_up(pos);
						owe(KIND_ACK, '0, ST_OK, 1'b1);
					end
				end
				OP_REMOVE_ALL: begin
					live_count = 0;
					owe(KIND_ACK, '0, ST_OK, 1'b1);
				end
				OP_TICK: begin
					i = 0;
					while (i < live_count) begin
						if (paused[i]) begin
							i++;
						end else if (remaining[i] < tv) begin
							owe(KIND_EXPIRE, ident[i], ST_OK, 1'b0);
							expiries++;
							close_up(i);
						end else begin
							remaining[i] = remaining[i] - tv;
							i++;
						end
					end
					owe(KIND_DONE, '0, ST_OK, 1'b1);
				end
				OP_SET_RUN: begin
					run_bit = flag;
					for (int j = 0; j < live_count; j++) paused[j] = !flag;
					owe(KIND_ACK, '0, ST_OK, 1'b1);
				end
				OP_FREEZE: begin
					pos = locate(tid);
					if (pos < 0) begin
						owe(KIND_ACK, '0, ST_NOT_FOUND, 1'b1);
					end else begin
						paused[pos] = flag;
						owe(KIND_ACK, '0, ST_OK, 1'b1);
					end
				end
				default: owe(KIND_ACK, '0, ST_OK, 1'b1);
			endcase
		endfunction

		function void check_result(logic [39:0] data, logic lst);
			timer_result_t want;
			logic [1:0]  got_kind;
			logic [31:0] got_id;
			logic [1:0]  got_status;
			got_kind = data[1:0];
			got_id = data[33:2];
			got_status = data[35:34];
			checked++;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected output transaction: kind %0d id %0h status %0d last %0b",
						got_kind, got_id, got_status, lst);
				return;
			end
			want = owed_results.pop_front();
			if (got_kind !== want.kind || got_id !== want.result_id ||
				got_status !== want.status || lst !== want.last || data[39:36] !== 4'd0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected kind %0d id %0h status %0d last %0b, got kind %0d id %0h status %0d last %0b fill %0h",
						want.kind, want.result_id, want.status, want.last,
						got_kind, got_id, got_status, lst, data[39:36]);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// Fields from bit 0: opcode, time_value, timer_id, flag, zero fill.
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// Fields from bit 0: kind, result_id, status, zero fill.
	logic [39:0] m_tdata;
	logic        m_tlast;

	timer_table_scoreboard board;
	// Sender and receiver idling controls. A hold-off stalls the receiver.
	bit          sender_idles;
	bit          receiver_idles;
	bit          hold_off;
	int          sent_items;

	one_shot_timer_table_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit: far beyond the slowest correct run of this length.
	initial begin
		#4ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: stalls at random unless idling is off, and stalls for good
	// while a hold-off is in force. Every accepted result is checked at once.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tlast);
		if (hold_off)
			m_tready <= 1'b0;
		else if (receiver_idles)
			m_tready <= ($urandom_range(99) >= 28);
		else
			m_tready <= 1'b1;
	end

	// Offers one input transaction and waits until the block takes it. The
	// prediction is updated at the accepting edge. The valid stays up after
	// the accepting edge until the next offer or the end of the stimulus.
	task automatic send_command(logic [2:0] op, logic [31:0] tv, logic [31:0] tid,
		logic flag);
		while (sender_idles && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, flag, tid, tv, op};
		do @(posedge clk); while (!s_tready);
		board.note_command(op, tv, tid, flag);
		sent_items++;
	endtask

	// An id near what is live, so lookups hit most of the time.
	function automatic logic [31:0] pick_id();
		if (board.live_count > 0 && $urandom_range(3) != 0)
			return board.ident[$urandom_range(board.live_count - 1)];
		return $urandom_range(3) == 0 ? $urandom : board.id_counter + $urandom_range(3);
	endfunction

	// Short durations so that ticks expire timers often; some full range.
	function automatic logic [31:0] pick_time();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'hFFFF_FFFF;
			default: return $urandom_range(32'h0004_0000);
		endcase
	endfunction

	task automatic random_command();
		int pick;
		pick = $urandom_range(99);
		if (pick < 38)
			send_command(OP_SCHEDULE, pick_time(), $urandom, $urandom_range(1));
		else if (pick < 48)
			send_command(OP_REMOVE, $urandom, pick_id(), $urandom_range(1));
		else if (pick < 50)
			send_command(OP_REMOVE_ALL, $urandom, $urandom, $urandom_range(1));
		else if (pick < 78)
			send_command(OP_TICK, $urandom_range(32'h0002_0000), $urandom,
				$urandom_range(1));
		else if (pick < 84)
			send_command(OP_SET_RUN, $urandom, $urandom, $urandom_range(3) != 0);
		else if (pick < 96)
			send_command(OP_FREEZE, $urandom, pick_id(), $urandom_range(1));
		else
			send_command(3'($urandom_range(7)), $urandom, $urandom, $urandom_range(1));
	endtask

	initial begin
		int waited;
		board = new();
		board.clear();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		hold_off = 1'b0;
		sent_items = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty-table lookups, extremes of time, the full
		// table, pause handling, unused opcodes and a tick that expires many.
		send_command(OP_REMOVE, '0, 32'd1, 1'b0);
		send_command(OP_FREEZE, '1, '1, 1'b1);
		send_command(OP_TICK, '1, '0, 1'b0);
		for (int i = 0; i < SLOTS; i++)
			send_command(OP_SCHEDULE, (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : i * 3,
				'1, 1'b0);
		send_command(OP_SCHEDULE, 32'd5, '0, 1'b1);
		send_command(OP_FREEZE, '0, 32'd3, 1'b1);
		send_command(OP_REMOVE, '1, 32'd2, 1'b1);
		send_command(OP_SET_RUN, '0, '0, 1'b0);
		send_command(OP_TICK, 32'd100, '0, 1'b1);
		send_command(OP_SET_RUN, '1, '1, 1'b1);
		send_command(3'd6, '1, '1, 1'b1);
		send_command(3'd7, '0, '0, 1'b0);
		send_command(OP_TICK, 32'd40, '1, 1'b0);
		send_command(OP_TICK, 32'hFFFF_FFFF, '0, 1'b0);
		send_command(OP_REMOVE_ALL, '0, '0, 1'b0);

		// Random part with idling on both sides.
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		for (int n = 0; n < 400; n++) begin
			if (n == 150) begin
				sender_idles = 1'b0;
				receiver_idles = 1'b0;
			end
			if (n == 230) begin
				sender_idles = 1'b1;
				receiver_idles = 1'b1;
			end
			// Long receiver hold-off while the sender keeps offering.
			if (n == 300) begin
				hold_off = 1'b1;
				fork
					begin
						repeat (300) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			random_command();
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (board.owed_results.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		$display("Sent %0d commands, checked %0d results including %0d timer expiries.",
			sent_items, board.checked, board.expiries);
		if (board.mismatches == 0 && board.owed_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived.", board.mismatches,
				board.owed_results.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
